// File: hw/rtl/tcp_pkg.sv
package tcp_pkg;

  localparam int CoordW = 24;
  localparam int RadW   = 20;
  localparam int DeltaW = CoordW + 1;
  localparam int SumW   = RadW + 1;

  typedef enum logic [1:0] {
    StExact      = 2'd0,
    StClamped    = 2'd1,
    StCoincident = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] y1;
    logic signed [DeltaW-1:0] dx;
    logic signed [DeltaW-1:0] dy;
    logic [SumW-1:0]          a;
    logic [SumW-1:0]          b;
    logic [RadW-1:0]          rn;
    logic                     coinc;
  } item_t;

endpackage

// File: hw/rtl/tangent_circle_placement.sv
// channel | direction | words                                          | handshake
// in      | input     | first_x/y, first_radius, second_x/y,           | in_valid_i, in_stall_o
//         |           | second_radius, new_radius                      |
// out     | output    | centre_x/y, placed_radius, status              | out_valid_o, out_stall_i
//
// One word per cycle in and out while neither side stalls; the back pipeline runs through
// the 47-stage square root and the 28-stage divider after the multiplier stages.
// Reset is asynchronous, active low, and clears the queue and valid bits only.
// A stalled output freezes the back pipeline; the front keeps taking words
// until the QUEUE_DEPTH queue fills, then raises in_stall_o.
module tangent_circle_placement #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [tcp_pkg::CoordW-1:0] first_x_i,
  input  logic signed [tcp_pkg::CoordW-1:0] first_y_i,
  input  logic [tcp_pkg::RadW-1:0]          first_radius_i,
  input  logic signed [tcp_pkg::CoordW-1:0] second_x_i,
  input  logic signed [tcp_pkg::CoordW-1:0] second_y_i,
  input  logic [tcp_pkg::RadW-1:0]          second_radius_i,
  input  logic [tcp_pkg::RadW-1:0]          new_radius_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [tcp_pkg::CoordW-1:0] centre_x_o,
  output logic signed [tcp_pkg::CoordW-1:0] centre_y_o,
  output logic [tcp_pkg::RadW-1:0]          placed_radius_o,
  output logic [1:0]                        status_o
);

  logic           push, pop, full, empty;
  tcp_pkg::item_t wr_item, rd_item;

  tcp_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .first_x_i, .first_y_i, .first_radius_i,
    .second_x_i, .second_y_i, .second_radius_i, .new_radius_i,
    .full_i(full), .push_o(push), .item_o(wr_item));

  tcp_fifo #(.DEPTH(QUEUE_DEPTH), .W($bits(tcp_pkg::item_t))) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .wdata_i(wr_item), .pop_i(pop),
    .rdata_o(rd_item), .full_o(full), .empty_o(empty));

  tcp_back u_back (
    .clk_i, .rst_ni, .item_i(rd_item), .empty_i(empty), .pop_o(pop),
    .out_valid_o, .out_stall_i, .centre_x_o, .centre_y_o,
    .placed_radius_o, .status_o);

endmodule

// File: hw/rtl/tcp_mul.sv
module tcp_mul #(
  parameter int WA = 26,
  parameter int WB = 26,
  parameter int PW = 1
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [WA-1:0]      a_i,
  input  logic [WB-1:0]      b_i,
  input  logic [PW-1:0]      side_i,
  output logic [WA+WB-1:0]   p_o,
  output logic [PW-1:0]      side_o
);

  localparam int H = 26;

  logic [2*H-1:0]   a_w, b_w;
  logic [2*H-1:0]   p00_q, p01_q, p10_q, p11_q;
  logic [PW-1:0]    side1_q, side2_q;
  logic [2*H:0]     mid;
  logic [4*H-1:0]   sum;
  logic [WA+WB-1:0] p_q;

  assign a_w = (2*H)'(a_i);
  assign b_w = (2*H)'(b_i);
  assign mid = (2*H+1)'(p01_q) + (2*H+1)'(p10_q);
  assign sum = {p11_q, p00_q} + ((4*H)'(mid) << H);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p00_q   <= a_w[H-1:0]   * b_w[H-1:0];
      p01_q   <= a_w[H-1:0]   * b_w[2*H-1:H];
      p10_q   <= a_w[2*H-1:H] * b_w[H-1:0];
      p11_q   <= a_w[2*H-1:H] * b_w[2*H-1:H];
      side1_q <= side_i;
      p_q     <= sum[WA+WB-1:0];
      side2_q <= side1_q;
    end
  end

  assign p_o    = p_q;
  assign side_o = side2_q;

endmodule

// File: hw/rtl/tcp_sqrt.sv
module tcp_sqrt #(
  parameter int W  = 94,
  parameter int PW = 1
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [W-1:0]   d_i,
  input  logic [PW-1:0]  side_i,
  output logic [W/2-1:0] root_o,
  output logic [PW-1:0]  side_o
);

  localparam int S  = W / 2;
  localparam int RW = S + 2;

  logic [RW-1:0] rem_q  [S];
  logic [S-1:0]  root_q [S];
  logic [W-1:0]  rad_q  [S];
  logic [PW-1:0] side_q [S];

  for (genvar i = 0; i < S; i++) begin : g_stage
    logic [RW-1:0] rem_in, rem_sh, trial;
    logic [S-1:0]  root_in;
    logic [W-1:0]  rad_in;
    logic [PW-1:0] side_in;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = d_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign rad_in  = rad_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign rem_sh = {rem_in[RW-3:0], rad_in[W-1:W-2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= ge ? rem_sh - trial : rem_sh;
        root_q[i] <= {root_in[S-2:0], ge};
        rad_q[i]  <= {rad_in[W-3:0], 2'b00};
        side_q[i] <= side_in;
      end
    end
  end

  assign root_o = root_q[S-1];
  assign side_o = side_q[S-1];

endmodule

// File: hw/rtl/tcp_div.sv
module tcp_div #(
  parameter int NW = 80,
  parameter int DW = 51,
  parameter int QW = 27,
  parameter int PW = 1
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [PW-1:0] side_i,
  output logic [QW-1:0] q_o,
  output logic          ovf_o,
  output logic [PW-1:0] side_o
);

  logic [NW-1:0] rem_q  [QW+1];
  logic [DW-1:0] den_q  [QW+1];
  logic [QW-1:0] q_q    [QW+1];
  logic          ovf_q  [QW+1];
  logic [PW-1:0] side_q [QW+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num_i;
      den_q[0]  <= den_i;
      q_q[0]    <= '0;
      ovf_q[0]  <= num_i >= (NW'(den_i) << QW);
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [NW-1:0] sub;
    logic          ge;

    assign sub = NW'(den_q[k-1]) << (QW - k);
    assign ge  = rem_q[k-1] >= sub;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? rem_q[k-1] - sub : rem_q[k-1];
        den_q[k]  <= den_q[k-1];
        q_q[k]    <= {q_q[k-1][QW-2:0], ge};
        ovf_q[k]  <= ovf_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign q_o    = q_q[QW];
  assign ovf_o  = ovf_q[QW];
  assign side_o = side_q[QW];

endmodule

// File: hw/rtl/tcp_fifo.sv
module tcp_fifo #(
  parameter int DEPTH = 4,
  parameter int W     = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o,
  output logic         full_o,
  output logic         empty_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign rdata_o = mem[rd_q];
  assign full_o  = cnt_q == CW'(DEPTH);
  assign empty_o = cnt_q == '0;

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("word pushed into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o)) else $error("word popped from empty queue");
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count lost a word");
`endif

endmodule

// File: hw/rtl/tcp_front.sv
module tcp_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [tcp_pkg::CoordW-1:0]   first_x_i,
  input  logic signed [tcp_pkg::CoordW-1:0]   first_y_i,
  input  logic [tcp_pkg::RadW-1:0]            first_radius_i,
  input  logic signed [tcp_pkg::CoordW-1:0]   second_x_i,
  input  logic signed [tcp_pkg::CoordW-1:0]   second_y_i,
  input  logic [tcp_pkg::RadW-1:0]            second_radius_i,
  input  logic [tcp_pkg::RadW-1:0]            new_radius_i,
  input  logic                                full_i,
  output logic                                push_o,
  output tcp_pkg::item_t                      item_o
);

  logic           vld_q, load;
  tcp_pkg::item_t item_d, item_q;

  always_comb begin
    item_d.x1    = first_x_i;
    item_d.y1    = first_y_i;
    item_d.dx    = tcp_pkg::DeltaW'(second_x_i) - tcp_pkg::DeltaW'(first_x_i);
    item_d.dy    = tcp_pkg::DeltaW'(second_y_i) - tcp_pkg::DeltaW'(first_y_i);
    item_d.a     = tcp_pkg::SumW'(first_radius_i) + tcp_pkg::SumW'(new_radius_i);
    item_d.b     = tcp_pkg::SumW'(second_radius_i) + tcp_pkg::SumW'(new_radius_i);
    item_d.rn    = new_radius_i;
    item_d.coinc = (second_x_i == first_x_i) && (second_y_i == first_y_i);
  end

  assign in_stall_o = vld_q && full_i;
  assign load       = !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      item_q <= item_d;
    end
  end

  assign push_o = vld_q && !full_i;
  assign item_o = item_q;

endmodule

// File: hw/rtl/tcp_back.sv
module tcp_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tcp_pkg::item_t                    item_i,
  input  logic                              empty_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [tcp_pkg::CoordW-1:0] centre_x_o,
  output logic signed [tcp_pkg::CoordW-1:0] centre_y_o,
  output logic [tcp_pkg::RadW-1:0]          placed_radius_o,
  output logic [1:0]                        status_o
);

  localparam int DW     = tcp_pkg::DeltaW;
  localparam int SqW    = 2 * tcp_pkg::SumW;
  localparam int LenW   = 2 * DW;
  localparam int NW     = LenW + 3;
  localparam int NMagW  = LenW + 1;
  localparam int FourW  = SqW + LenW + 2;
  localparam int NsqW   = 2 * NMagW;
  localparam int RootW  = FourW / 2;
  localparam int PnW    = DW + NMagW;
  localparam int PtW    = DW + RootW;
  localparam int PlW    = 80;
  localparam int DenW   = LenW + 1;
  localparam int QuotW  = 27;
  localparam int SumOW  = QuotW + 2;
  localparam int MulLat = 2;
  localparam int PipeLat = MulLat + 1 + MulLat + 1 + RootW + MulLat + 1 + 1 + QuotW + 1;

  localparam logic [QuotW-1:0] OffLimit = QuotW'(1) << (QuotW - 1);
  localparam logic signed [SumOW-1:0] CoordMax = SumOW'(8388607);
  localparam logic signed [SumOW-1:0] CoordMin = -SumOW'(8388608);

  typedef struct packed {
    tcp_pkg::item_t  it;
    logic [LenW-1:0] l;
    logic            nneg;
  } s2_t;

  typedef struct packed {
    tcp_pkg::item_t        it;
    logic [LenW-1:0]       l;
    logic                  clamp;
    logic signed [PnW:0]   dxn;
    logic signed [PnW:0]   dyn;
  } s3_t;

  typedef struct packed {
    tcp_pkg::item_t        it;
    logic [LenW-1:0]       l;
    logic                  clamp;
    logic signed [PlW-1:0] nx;
    logic signed [PlW-1:0] ny;
  } s4_t;

  typedef struct packed {
    logic signed [tcp_pkg::CoordW-1:0] x1;
    logic signed [tcp_pkg::CoordW-1:0] y1;
    logic [tcp_pkg::RadW-1:0]          rn;
    logic                              coinc;
    logic                              clamp;
    logic                              negx;
    logic                              negy;
  } s5_t;

  function automatic logic signed [tcp_pkg::CoordW-1:0] place(
    input logic signed [tcp_pkg::CoordW-1:0] base,
    input logic [QuotW-1:0]                  q,
    input logic                              ovf,
    input logic                              neg
  );
    logic [QuotW-1:0]        m;
    logic signed [QuotW:0]   off;
    logic signed [SumOW-1:0] sum;
    m   = (ovf || q > OffLimit) ? OffLimit : q;
    off = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    sum = SumOW'(base) + SumOW'(off);
    if (sum > CoordMax) begin
      sum = CoordMax;
    end else if (sum < CoordMin) begin
      sum = CoordMin;
    end
    return sum[tcp_pkg::CoordW-1:0];
  endfunction

  logic                en;
  logic [PipeLat-1:0]  vld_q;
  logic                out_vld_q;

  assign en    = !out_vld_q || !out_stall_i;
  assign pop_o = en && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[PipeLat-2:0], pop_o};
      out_vld_q <= vld_q[PipeLat-1];
    end
  end

  // squares of the deltas and of the grown radii
  logic [DW-1:0]   dx_mag0, dy_mag0;
  logic [LenW-1:0] dxx, dyy;
  logic [SqW-1:0]  aa, bb;
  tcp_pkg::item_t  it1;

  assign dx_mag0 = item_i.dx[DW-1] ? DW'(-item_i.dx) : DW'(item_i.dx);
  assign dy_mag0 = item_i.dy[DW-1] ? DW'(-item_i.dy) : DW'(item_i.dy);

  tcp_mul #(.WA(DW), .WB(DW), .PW($bits(tcp_pkg::item_t))) u_mul_dxx (
    .clk_i, .en_i(en), .a_i(dx_mag0), .b_i(dx_mag0), .side_i(item_i),
    .p_o(dxx), .side_o(it1));
  tcp_mul #(.WA(DW), .WB(DW), .PW(1)) u_mul_dyy (
    .clk_i, .en_i(en), .a_i(dy_mag0), .b_i(dy_mag0), .side_i(1'b0),
    .p_o(dyy), .side_o());
  tcp_mul #(.WA(tcp_pkg::SumW), .WB(tcp_pkg::SumW), .PW(1)) u_mul_aa (
    .clk_i, .en_i(en), .a_i(item_i.a), .b_i(item_i.a), .side_i(1'b0),
    .p_o(aa), .side_o());
  tcp_mul #(.WA(tcp_pkg::SumW), .WB(tcp_pkg::SumW), .PW(1)) u_mul_bb (
    .clk_i, .en_i(en), .a_i(item_i.b), .b_i(item_i.b), .side_i(1'b0),
    .p_o(bb), .side_o());

  // L and N
  logic [LenW-1:0]      l_d;
  logic signed [NW-1:0] n_d;
  s2_t                  s2_q;
  logic [SqW-1:0]       a2_q;
  logic [NMagW-1:0]     nmag_q;

  assign l_d = dxx + dyy;
  assign n_d = $signed(NW'(aa)) - $signed(NW'(bb)) + $signed(NW'(l_d));

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q.it   <= it1;
      s2_q.l    <= l_d;
      s2_q.nneg <= n_d[NW-1];
      a2_q      <= aa;
      nmag_q    <= n_d[NW-1] ? NMagW'(-n_d) : NMagW'(n_d);
    end
  end

  logic [DW-1:0]    dx_mag2, dy_mag2;
  logic [FourW-3:0] a2l;
  logic [NsqW-1:0]  nsq;
  logic [PnW-1:0]   dxnp, dynp;
  s2_t              s2m;

  assign dx_mag2 = s2_q.it.dx[DW-1] ? DW'(-s2_q.it.dx) : DW'(s2_q.it.dx);
  assign dy_mag2 = s2_q.it.dy[DW-1] ? DW'(-s2_q.it.dy) : DW'(s2_q.it.dy);

  tcp_mul #(.WA(SqW), .WB(LenW), .PW($bits(s2_t))) u_mul_al (
    .clk_i, .en_i(en), .a_i(a2_q), .b_i(s2_q.l), .side_i(s2_q),
    .p_o(a2l), .side_o(s2m));
  tcp_mul #(.WA(NMagW), .WB(NMagW), .PW(1)) u_mul_nn (
    .clk_i, .en_i(en), .a_i(nmag_q), .b_i(nmag_q), .side_i(1'b0),
    .p_o(nsq), .side_o());
  tcp_mul #(.WA(DW), .WB(NMagW), .PW(1)) u_mul_dxn (
    .clk_i, .en_i(en), .a_i(dx_mag2), .b_i(nmag_q), .side_i(1'b0),
    .p_o(dxnp), .side_o());
  tcp_mul #(.WA(DW), .WB(NMagW), .PW(1)) u_mul_dyn (
    .clk_i, .en_i(en), .a_i(dy_mag2), .b_i(nmag_q), .side_i(1'b0),
    .p_o(dynp), .side_o());

  // radicand and clamp
  logic signed [NsqW:0] diff;
  logic                 clamp_d;
  s3_t                  s3_q;
  logic [FourW-1:0]     d_q;

  assign diff    = $signed((NsqW+1)'({a2l, 2'b00})) - $signed((NsqW+1)'(nsq));
  assign clamp_d = diff[NsqW] || (diff == '0);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q.it    <= s2m.it;
      s3_q.l     <= s2m.l;
      s3_q.clamp <= clamp_d;
      s3_q.dxn   <= (s2m.it.dx[DW-1] ^ s2m.nneg) ? -$signed({1'b0, dxnp})
                                                  : $signed({1'b0, dxnp});
      s3_q.dyn   <= (s2m.it.dy[DW-1] ^ s2m.nneg) ? -$signed({1'b0, dynp})
                                                  : $signed({1'b0, dynp});
      d_q        <= clamp_d ? '0 : diff[FourW-1:0];
    end
  end

  logic [RootW-1:0] t;
  s3_t              s3s;

  tcp_sqrt #(.W(FourW), .PW($bits(s3_t))) u_sqrt (
    .clk_i, .en_i(en), .d_i(d_q), .side_i(s3_q), .root_o(t), .side_o(s3s));

  logic [DW-1:0]  dx_mag3, dy_mag3;
  logic [PtW-1:0] dytp, dxtp;
  s3_t            s3m;

  assign dx_mag3 = s3s.it.dx[DW-1] ? DW'(-s3s.it.dx) : DW'(s3s.it.dx);
  assign dy_mag3 = s3s.it.dy[DW-1] ? DW'(-s3s.it.dy) : DW'(s3s.it.dy);

  tcp_mul #(.WA(DW), .WB(RootW), .PW($bits(s3_t))) u_mul_dyt (
    .clk_i, .en_i(en), .a_i(dy_mag3), .b_i(t), .side_i(s3s),
    .p_o(dytp), .side_o(s3m));
  tcp_mul #(.WA(DW), .WB(RootW), .PW(1)) u_mul_dxt (
    .clk_i, .en_i(en), .a_i(dx_mag3), .b_i(t), .side_i(1'b0),
    .p_o(dxtp), .side_o());

  // numerators with the rounding half added
  logic signed [PtW:0]   dyt_s, dxt_s;
  logic signed [PlW-1:0] l_ext;
  s4_t                   s4_q;

  assign dyt_s = s3m.it.dy[DW-1] ? -$signed({1'b0, dytp}) : $signed({1'b0, dytp});
  assign dxt_s = s3m.it.dx[DW-1] ? -$signed({1'b0, dxtp}) : $signed({1'b0, dxtp});
  assign l_ext = $signed(PlW'(s3m.l));

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_q.it    <= s3m.it;
      s4_q.l     <= s3m.l;
      s4_q.clamp <= s3m.clamp;
      s4_q.nx    <= PlW'(s3m.dxn) + PlW'(dyt_s) + l_ext;
      s4_q.ny    <= PlW'(s3m.dyn) - PlW'(dxt_s) + l_ext;
    end
  end

  // fold negative numerators so the divider rounds their magnitude up and the signed result down
  logic [DenW-1:0] two_l;
  logic [PlW-1:0]  nx_u, ny_u;
  logic [PlW-1:0]  numx_q, numy_q;
  logic [DenW-1:0] den_q;
  s5_t             s5_q;

  assign two_l = {s4_q.l, 1'b0};
  assign nx_u  = s4_q.nx;
  assign ny_u  = s4_q.ny;

  always_ff @(posedge clk_i) begin
    if (en) begin
      numx_q     <= nx_u[PlW-1] ? ~nx_u + PlW'(two_l) : nx_u;
      numy_q     <= ny_u[PlW-1] ? ~ny_u + PlW'(two_l) : ny_u;
      den_q      <= two_l;
      s5_q.x1    <= s4_q.it.x1;
      s5_q.y1    <= s4_q.it.y1;
      s5_q.rn    <= s4_q.it.rn;
      s5_q.coinc <= s4_q.it.coinc;
      s5_q.clamp <= s4_q.clamp;
      s5_q.negx  <= nx_u[PlW-1];
      s5_q.negy  <= ny_u[PlW-1];
    end
  end

  logic [QuotW-1:0] qx, qy;
  logic             ovfx, ovfy;
  s5_t              s5d;

  tcp_div #(.NW(PlW), .DW(DenW), .QW(QuotW), .PW($bits(s5_t))) u_div_x (
    .clk_i, .en_i(en), .num_i(numx_q), .den_i(den_q), .side_i(s5_q),
    .q_o(qx), .ovf_o(ovfx), .side_o(s5d));
  tcp_div #(.NW(PlW), .DW(DenW), .QW(QuotW), .PW(1)) u_div_y (
    .clk_i, .en_i(en), .num_i(numy_q), .den_i(den_q), .side_i(1'b0),
    .q_o(qy), .ovf_o(ovfy), .side_o());

  logic signed [tcp_pkg::CoordW-1:0] cx_q, cy_q;
  logic [tcp_pkg::RadW-1:0]          rn_q;
  tcp_pkg::status_e                  status_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q <= s5d.coinc ? '0 : place(s5d.x1, qx, ovfx, s5d.negx);
      cy_q <= s5d.coinc ? '0 : place(s5d.y1, qy, ovfy, s5d.negy);
      rn_q <= s5d.rn;
      priority if (s5d.coinc) begin
        status_q <= tcp_pkg::StCoincident;
      end else if (s5d.clamp) begin
        status_q <= tcp_pkg::StClamped;
      end else begin
        status_q <= tcp_pkg::StExact;
      end
    end
  end

  assign out_valid_o     = out_vld_q;
  assign centre_x_o      = cx_q;
  assign centre_y_o      = cy_q;
  assign placed_radius_o = rn_q;
  assign status_o        = status_q;

endmodule

// File: dv/tcp_checker.sv
`timescale 1ns / 100ps

module tcp_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic signed [tcp_pkg::CoordW-1:0] first_x_i,
  input  logic signed [tcp_pkg::CoordW-1:0] first_y_i,
  input  logic [tcp_pkg::RadW-1:0]          first_radius_i,
  input  logic signed [tcp_pkg::CoordW-1:0] second_x_i,
  input  logic signed [tcp_pkg::CoordW-1:0] second_y_i,
  input  logic [tcp_pkg::RadW-1:0]          second_radius_i,
  input  logic [tcp_pkg::RadW-1:0]          new_radius_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic signed [tcp_pkg::CoordW-1:0] centre_x_i,
  input  logic signed [tcp_pkg::CoordW-1:0] centre_y_i,
  input  logic [tcp_pkg::RadW-1:0]          placed_radius_i,
  input  logic [1:0]                        status_i,
  output int                                fail_count_o,
  output int                                pending_o
);

  typedef struct {
    logic signed [tcp_pkg::CoordW-1:0] cx;
    logic signed [tcp_pkg::CoordW-1:0] cy;
    logic [tcp_pkg::RadW-1:0]          rad;
    logic [1:0]                        status;
  } placement_t;

  placement_t placements_q[$];

  function automatic logic [63:0] isqrt(logic [127:0] v);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [127:0] sq;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (64'd1 << i);
      sq = {64'd0, c} * {64'd0, c};
      if (sq <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic signed [tcp_pkg::CoordW-1:0] offset_coord(
      logic signed [127:0] base, logic signed [127:0] num, logic signed [127:0] len);
    logic signed [127:0] n;
    logic signed [127:0] q;
    logic signed [127:0] lim;
    logic signed [127:0] sum;
    lim = 128'sd1 <<< 26;
    n = num + len;
    if (n >= 0) q = n / (2 * len);
    else q = -((-n + 2 * len - 1) / (2 * len));
    if (q > lim) q = lim;
    if (q < -lim) q = -lim;
    sum = base + q;
    if (sum > 128'sd8388607) sum = 128'sd8388607;
    if (sum < -128'sd8388608) sum = -128'sd8388608;
    return sum[tcp_pkg::CoordW-1:0];
  endfunction

  function automatic placement_t place_circle(logic signed [tcp_pkg::CoordW-1:0] x1,
      logic signed [tcp_pkg::CoordW-1:0] y1, logic [tcp_pkg::RadW-1:0] r1,
      logic signed [tcp_pkg::CoordW-1:0] x2, logic signed [tcp_pkg::CoordW-1:0] y2,
      logic [tcp_pkg::RadW-1:0] r2, logic [tcp_pkg::RadW-1:0] rn);
    placement_t p;
    logic signed [127:0] dx, dy, len, a, b, n, four, nsq, t;
    dx = 128'(x2) - 128'(x1);
    dy = 128'(y2) - 128'(y1);
    len = dx * dx + dy * dy;
    a = 128'(r1) + 128'(rn);
    b = 128'(r2) + 128'(rn);
    p.rad = rn;
    if (len == 0) begin
      p.cx = '0;
      p.cy = '0;
      p.status = tcp_pkg::StCoincident;
      return p;
    end
    n = a * a - b * b + len;
    four = 4 * a * a * len;
    nsq = n * n;
    t = 0;
    if (four <= nsq) begin
      p.status = tcp_pkg::StClamped;
    end else begin
      p.status = tcp_pkg::StExact;
      t = 128'(isqrt(four - nsq));
    end
    p.cx = offset_coord(128'(x1), dx * n + dy * t, len);
    p.cy = offset_coord(128'(y1), dy * n - dx * t, len);
    return p;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
  end

  assign pending_o = placements_q.size();

  always @(posedge clk_i) begin
    placement_t e;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i)
        placements_q.insert(placements_q.size(),
            place_circle(first_x_i, first_y_i, first_radius_i,
            second_x_i, second_y_i, second_radius_i, new_radius_i));
      if (out_valid_i && !out_stall_i) begin
        if (placements_q.size() == 0) begin
          report_mismatch("unexpected word", 0, 0);
        end else begin
          e = placements_q.pop_front();
          if (centre_x_i !== e.cx) report_mismatch("centre_x", centre_x_i, e.cx);
          if (centre_y_i !== e.cy) report_mismatch("centre_y", centre_y_i, e.cy);
          if (placed_radius_i !== e.rad)
            report_mismatch("placed_radius", placed_radius_i, e.rad);
          if (status_i !== e.status) report_mismatch("status", status_i, e.status);
        end
      end
    end
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int WatchLimit = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [tcp_pkg::CoordW-1:0] fx = '0, fy = '0, sx = '0, sy = '0;
  logic [tcp_pkg::RadW-1:0] fr = '0, sr = '0, nr = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [tcp_pkg::CoordW-1:0] cx, cy;
  logic [tcp_pkg::RadW-1:0] prad;
  logic [1:0] status;
  int fails, pending;
  logic in_taken = 1'b0;
  logic any_taken = 1'b0;
  int idle_cycles = 0;
  int stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tangent_circle_placement dut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .first_x_i(fx), .first_y_i(fy), .first_radius_i(fr),
    .second_x_i(sx), .second_y_i(sy), .second_radius_i(sr), .new_radius_i(nr),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .centre_x_o(cx), .centre_y_o(cy), .placed_radius_o(prad), .status_o(status)
  );

  tcp_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_i(in_stall),
    .first_x_i(fx), .first_y_i(fy), .first_radius_i(fr),
    .second_x_i(sx), .second_y_i(sy), .second_radius_i(sr), .new_radius_i(nr),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .centre_x_i(cx), .centre_y_i(cy), .placed_radius_i(prad), .status_i(status),
    .fail_count_o(fails), .pending_o(pending)
  );

  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
    any_taken <= (in_valid && !in_stall) || (out_valid && !out_stall);
  end

  // drop the run when nothing moves for too long
  always @(negedge clk) begin
    if (any_taken) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(negedge clk) begin
    int k;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      k = $urandom_range(0, 99);
      if (k < 75) begin
        out_stall <= 1'b0;
      end else if (k < 97) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(0, 6);
      end else begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(20, 60);
      end
    end
  end

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 50);
  endfunction

  task automatic send_word(logic signed [tcp_pkg::CoordW-1:0] x1,
      logic signed [tcp_pkg::CoordW-1:0] y1, logic [tcp_pkg::RadW-1:0] r1,
      logic signed [tcp_pkg::CoordW-1:0] x2, logic signed [tcp_pkg::CoordW-1:0] y2,
      logic [tcp_pkg::RadW-1:0] r2, logic [tcp_pkg::RadW-1:0] rn);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    fx <= x1; fy <= y1; fr <= r1; sx <= x2; sy <= y2; sr <= r2; nr <= rn;
    do @(negedge clk); while (!in_taken);
  endtask

  task automatic send_random();
    logic signed [tcp_pkg::CoordW-1:0] x1, y1;
    logic [tcp_pkg::RadW-1:0] r1, r2, rn;
    int k, span;
    k = $urandom_range(0, 99);
    if (k < 25) begin
      send_word(tcp_pkg::CoordW'($urandom), tcp_pkg::CoordW'($urandom),
          tcp_pkg::RadW'($urandom), tcp_pkg::CoordW'($urandom),
          tcp_pkg::CoordW'($urandom), tcp_pkg::RadW'($urandom), tcp_pkg::RadW'($urandom));
    end else begin
      span = (k < 60) ? 4096 : 65536;
      x1 = tcp_pkg::CoordW'($urandom);
      y1 = tcp_pkg::CoordW'($urandom);
      if (k < 30) begin
        x1 = x1 >>> 4;
        y1 = y1 >>> 4;
      end
      r1 = tcp_pkg::RadW'($urandom_range(0, span));
      r2 = tcp_pkg::RadW'($urandom_range(0, span));
      rn = tcp_pkg::RadW'($urandom_range(0, span));
      send_word(x1, y1, r1,
          tcp_pkg::CoordW'(x1 + $signed($urandom_range(0, 2 * span)) - span),
          tcp_pkg::CoordW'(y1 + $signed($urandom_range(0, 2 * span)) - span), r2, rn);
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_word(0, 0, 256, 512, 0, 256, 0);
    send_word(100, 200, 300, 100, 200, 400, 500);
    send_word(-8388608, -8388608, 0, -8388608, -8388608, 0, 0);
    send_word(-8388608, -8388608, 1048575, 8388607, 8388607, 1048575, 1048575);
    send_word(8388607, 8388607, 0, -8388608, -8388608, 0, 0);
    send_word(0, 0, 10, 100000, 0, 10, 10);
    send_word(0, 0, 1048575, 1, 0, 0, 1048575);
    send_word(8388000, 8388000, 1048575, 8388607, 8388600, 1048575, 1048575);
    send_word(-8388000, -8388000, 1048575, -8388608, -8388600, 1048575, 1048575);
    send_word(0, 0, 0, 0, 1, 0, 0);
    send_word(0, 0, 1, 2, 0, 1, 0);
    send_word(0, 0, 1048575, 0, 3, 1048575, 0);
    send_word(1000, -1000, 5000, -3000, 2000, 4000, 700);
    send_word(-5, 7, 1048575, 3, -9, 1, 1048575);
    send_word(8388607, -8388608, 12345, -8388608, 8388607, 54321, 99999);
    repeat (800) send_random();
    // hold until the pipeline has drained
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (850) send_random();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fails == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
